FILE: hdl/kld_pkg.sv
// kld_pkg: shared types, constants and command codes of the sample size bound unit
// no dependencies; imported by every module of the block
package kld_pkg;

   // histogram geometry
   localparam int DIMS       = 4;
   localparam int MAX_BINS   = 256;
   localparam int DIM_W      = 2;
   localparam int BIN_W      = 8;
   localparam int MARK_AW    = DIM_W + BIN_W;
   localparam int MARK_DEPTH = 1 << MARK_AW;

   // arithmetic constants
   localparam logic [16:0] Z_Q16      = 17'd104858;
   localparam logic [23:0] TAKEN_MAX  = 24'hFF_FFFF;
   localparam logic [10:0] OCC_MAX    = 11'd2047;
   localparam logic [39:0] TARGET_MAX = 40'hFF_FFFF_FFFF;

   // register reset values
   localparam logic [8:0]  NUM_BINS_RST    = 9'd150;
   localparam logic [15:0] EPS_RST         = 16'd6554;
   localparam logic [15:0] MIN_SAMPLES_RST = 16'd1800;

   // register indexes
   localparam logic [1:0] REG_NUM_BINS    = 2'd0;
   localparam logic [1:0] REG_EPSILON     = 2'd1;
   localparam logic [1:0] REG_MIN_SAMPLES = 2'd2;

   // request codes
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_BOUNDS = 2'd1;
   localparam logic [1:0] REQ_SAMPLE = 2'd2;

   // datapath operation codes
   localparam logic [4:0] OP_NONE       = 5'd0;
   localparam logic [4:0] OP_LATCH      = 5'd1;
   localparam logic [4:0] OP_CLR_STEP   = 5'd2;
   localparam logic [4:0] OP_ROUND_INIT = 5'd3;
   localparam logic [4:0] OP_BOUNDS     = 5'd4;
   localparam logic [4:0] OP_TAKEN      = 5'd5;
   localparam logic [4:0] OP_NEXT_DIM   = 5'd6;
   localparam logic [4:0] OP_BIN_ZERO   = 5'd7;
   localparam logic [4:0] OP_BIN_MUL    = 5'd8;
   localparam logic [4:0] OP_BIN_DIV    = 5'd9;
   localparam logic [4:0] OP_BIN_CLAMP  = 5'd10;
   localparam logic [4:0] OP_MEM_RD     = 5'd11;
   localparam logic [4:0] OP_MARK       = 5'd12;
   localparam logic [4:0] OP_T_DIV      = 5'd13;
   localparam logic [4:0] OP_SQ_INIT    = 5'd14;
   localparam logic [4:0] OP_SQ_STEP    = 5'd15;
   localparam logic [4:0] OP_L_MUL      = 5'd16;
   localparam logic [4:0] OP_L_SUM      = 5'd17;
   localparam logic [4:0] OP_C_MUL1     = 5'd18;
   localparam logic [4:0] OP_C_MUL2     = 5'd19;
   localparam logic [4:0] OP_V_MUL      = 5'd20;
   localparam logic [4:0] OP_V_DIV      = 5'd21;
   localparam logic [4:0] OP_TGT_SET    = 5'd22;
   localparam logic [4:0] OP_RESP       = 5'd23;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [1:0]         dim_index;
      logic signed [31:0] bound_low;
      logic signed [31:0] bound_high;
      logic signed [31:0] sample_0;
      logic signed [31:0] sample_1;
      logic signed [31:0] sample_2;
      logic signed [31:0] sample_3;
   } kld_req_type;

   typedef struct packed {
      logic        new_bin;
      logic [10:0] bins_occupied;
      logic [23:0] samples_taken;
      logic [23:0] sample_target;
      logic        done_res;
   } kld_rsp_type;

   typedef struct packed {
      logic [4:0] op;
   } kld_cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       in_range;
      logic       zero_range;
      logic       dim_last;
      logic       div_done;
      logic       sq_last;
      logic       mark_set;
      logic       occ_nz;
      logic [1:0] req_code;
   } kld_stat_type;

endpackage

FILE: hdl/kld_div.sv
// kld_div: shared restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// depends on kld_pkg
module kld_div
   import kld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0] dq_ff;
   logic [31:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   // one restoring step
   assign shifted = {rem_ff, dq_ff[63]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         dq_ff   <= '0;
         dvs_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dq_ff   <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[31:0] : shifted[31:0];
            dq_ff  <= {dq_ff[62:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

   // a new division never cuts into one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

   // done only at the end of a run
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

endmodule

FILE: hdl/kld_dp.sv
// kld_dp: datapath of the sample size bound unit: bounds, bin mark memory,
// counters, target arithmetic; depends on kld_pkg and kld_div
module kld_dp
   import kld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  kld_cmd_type  cmd,
   input  kld_req_type  req_in,
   input  logic [8:0]   num_bins,
   input  logic [15:0]  epsilon,
   input  logic [15:0]  min_samples,
   output kld_stat_type stat,
   output logic         rsp_valid,
   output kld_rsp_type  rsp_data
);

   localparam logic [MARK_AW-1:0] CLR_LAST   = MARK_AW'(MARK_DEPTH - 1);
   localparam logic [DIM_W-1:0]   DIM_LAST   = DIM_W'(DIMS - 1);
   localparam logic [8:0]         MAX_BINS_V = 9'(MAX_BINS);

   kld_req_type        req_ff;
   logic signed [31:0] lo_ff [DIMS];
   logic signed [31:0] hi_ff [DIMS];
   logic [10:0]        occ_ff;
   logic [23:0]        taken_ff;
   logic [39:0]        target_ff;
   logic               newb_ff;
   logic [DIM_W-1:0]   dim_ff;
   logic [BIN_W-1:0]   bin_ff;
   logic [40:0]        prod_ff;
   logic               mark_rd_ff;
   logic [MARK_AW-1:0] clr_ptr_ff;
   logic [31:0]        t_ff;
   logic [63:0]        x_ff;
   logic [63:0]        res_ff;
   logic [4:0]         sq_cnt_ff;
   logic [48:0]        mz_ff;
   logic [25:0]        l24_ff;
   logic [51:0]        p1_ff;
   logic [53:0]        p2_ff;
   logic [40:0]        vm_ff;
   kld_rsp_type        rsp_ff;
   logic               rsp_valid_ff;
   logic               mark_mem [MARK_DEPTH];

   logic signed [31:0] samp;
   logic signed [31:0] lo_cur;
   logic signed [31:0] hi_cur;
   logic [31:0]        diff_s;
   logic [31:0]        rng;
   logic               in_range;
   logic [8:0]         nb_eff;
   logic [15:0]        eps_eff;
   logic [10:0]        n_val;
   logic [63:0]        sq_bit;
   logic [63:0]        sq_sum;
   logic               sq_ge;
   logic [33:0]        l_val;
   logic               div_start;
   logic [63:0]        div_dvd;
   logic [31:0]        div_dvs;
   logic               div_done;
   logic [63:0]        quo;
   logic               done_now;

   // component and bounds of the dimension under test
   always_comb begin
      case (dim_ff)
         2'd0:    samp = req_ff.sample_0;
         2'd1:    samp = req_ff.sample_1;
         2'd2:    samp = req_ff.sample_2;
         default: samp = req_ff.sample_3;
      endcase
   end
   assign lo_cur   = lo_ff[dim_ff];
   assign hi_cur   = hi_ff[dim_ff];
   assign in_range = !(samp < lo_cur) && !(samp > hi_cur);
   assign diff_s   = samp - lo_cur;
   assign rng      = hi_cur - lo_cur;

   // effective register values
   assign nb_eff  = (num_bins == 9'd0) ? 9'd1 :
                    (num_bins > MAX_BINS_V) ? MAX_BINS_V : num_bins;
   assign eps_eff = (epsilon == 16'd0) ? 16'd1 : epsilon;
   assign n_val   = occ_ff - 11'd1;

   // integer square root step
   assign sq_bit = 64'd1 << (6'd62 - {sq_cnt_ff, 1'b0});
   assign sq_sum = res_ff + sq_bit;
   assign sq_ge  = x_ff >= sq_sum;

   // 1 - t + 1.6 * sqrt(t), Q.32
   assign l_val = 34'h1_0000_0000 - 34'(t_ff) + 34'(mz_ff[48:16]);

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_dvd   = {23'd0, prod_ff};
      div_dvs   = rng;
      case (cmd.op)
         OP_BIN_DIV: div_start = 1'b1;
         OP_T_DIV: begin
            div_start = 1'b1;
            div_dvd   = 64'h2_0000_0000;
            div_dvs   = 32'({n_val, 3'b000}) + 32'(n_val);
         end
         OP_V_DIV: begin
            div_start = 1'b1;
            div_dvd   = {8'd0, vm_ff, 15'd0};
            div_dvs   = {8'd0, eps_eff, 8'd0};
         end
         default: ;
      endcase
   end

   kld_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (quo)
   );

   assign done_now = ({taken_ff, 16'd0} >= target_ff) && (taken_ff >= {8'd0, min_samples});

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff       <= '0;
         occ_ff       <= '0;
         taken_ff     <= '0;
         target_ff    <= {8'd0, MIN_SAMPLES_RST, 16'd0};
         newb_ff      <= 1'b0;
         dim_ff       <= '0;
         bin_ff       <= '0;
         clr_ptr_ff   <= '0;
         sq_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIMS; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_LATCH: begin
               req_ff  <= req_in;
               newb_ff <= 1'b0;
            end
            OP_CLR_STEP:   clr_ptr_ff <= clr_ptr_ff + 1'b1;
            OP_ROUND_INIT: begin
               occ_ff    <= '0;
               taken_ff  <= '0;
               target_ff <= {8'd0, min_samples, 16'd0};
            end
            OP_BOUNDS: begin
               if ({1'b0, req_ff.dim_index} < 3'(DIMS)) begin
                  lo_ff[req_ff.dim_index] <= req_ff.bound_low;
                  hi_ff[req_ff.dim_index] <= req_ff.bound_high;
               end
            end
            OP_TAKEN: begin
               if (taken_ff != TAKEN_MAX) taken_ff <= taken_ff + 24'd1;
               dim_ff <= '0;
            end
            OP_NEXT_DIM:  dim_ff  <= dim_ff + 1'b1;
            OP_BIN_ZERO:  bin_ff  <= '0;
            OP_BIN_MUL:   prod_ff <= diff_s * nb_eff;
            OP_BIN_CLAMP: bin_ff  <= (quo >= {55'd0, nb_eff}) ?
                                     BIN_W'(nb_eff - 9'd1) : quo[BIN_W-1:0];
            OP_MEM_RD:    mark_rd_ff <= mark_mem[{dim_ff, bin_ff}];
            OP_MARK: begin
               newb_ff <= 1'b1;
               if (occ_ff != OCC_MAX) occ_ff <= occ_ff + 11'd1;
            end
            OP_SQ_INIT: begin
               t_ff      <= quo[31:0];
               x_ff      <= {quo[31:0], 32'd0};
               res_ff    <= '0;
               sq_cnt_ff <= '0;
            end
            OP_SQ_STEP: begin
               if (sq_ge) begin
                  x_ff   <= x_ff - sq_sum;
                  res_ff <= (res_ff >> 1) + sq_bit;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               sq_cnt_ff <= sq_cnt_ff + 5'd1;
            end
            OP_L_MUL:   mz_ff  <= res_ff[31:0] * Z_Q16;
            OP_L_SUM:   l24_ff <= l_val[33:8];
            OP_C_MUL1:  p1_ff  <= l24_ff * l24_ff;
            OP_C_MUL2:  p2_ff  <= p1_ff[51:24] * l24_ff;
            OP_V_MUL:   vm_ff  <= n_val * p2_ff[53:24];
            OP_TGT_SET: target_ff <= (quo > {24'd0, TARGET_MAX}) ? TARGET_MAX : quo[39:0];
            OP_RESP: begin
               rsp_valid_ff          <= 1'b1;
               rsp_ff.new_bin        <= newb_ff;
               rsp_ff.bins_occupied  <= occ_ff;
               rsp_ff.samples_taken  <= taken_ff;
               rsp_ff.sample_target  <= target_ff[39:16];
               rsp_ff.done_res       <= done_now;
            end
            default: ;
         endcase
      end
   end

   // bin mark memory, one write port
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLR_STEP) begin
         mark_mem[clr_ptr_ff] <= 1'b0;
      end else if (cmd.op == OP_MARK) begin
         mark_mem[{dim_ff, bin_ff}] <= 1'b1;
      end
   end

   // status to the controller
   assign stat.clr_last   = clr_ptr_ff == CLR_LAST;
   assign stat.in_range   = in_range;
   assign stat.zero_range = rng == 32'd0;
   assign stat.dim_last   = dim_ff == DIM_LAST;
   assign stat.div_done   = div_done;
   assign stat.sq_last    = sq_cnt_ff == 5'd31;
   assign stat.mark_set   = mark_rd_ff;
   assign stat.occ_nz     = occ_ff != 11'd0;
   assign stat.req_code   = req_ff.req_type;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one result strobe per item
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe longer than one cycle");

   // a bin is marked only when it was read as empty
   a_mark_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_MARK) |-> !mark_rd_ff) else $error("marking an occupied bin");

   // the target unit only runs with more than one bin occupied
   a_target_n: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_T_DIV) |-> (occ_ff > 11'd1)) else $error("target with one bin");

endmodule

FILE: hdl/kld_ctrl.sv
// kld_ctrl: sequencer of the sample size bound unit, issues datapath operations
// depends on kld_pkg
module kld_ctrl
   import kld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  kld_stat_type stat,
   output logic         busy,
   output kld_cmd_type  cmd
);

   localparam logic [4:0] S_RST_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_DECODE    = 5'd2;
   localparam logic [4:0] S_CLR       = 5'd3;
   localparam logic [4:0] S_INIT      = 5'd4;
   localparam logic [4:0] S_BOUNDS    = 5'd5;
   localparam logic [4:0] S_TAKEN     = 5'd6;
   localparam logic [4:0] S_DIM       = 5'd7;
   localparam logic [4:0] S_BIN_DIV   = 5'd8;
   localparam logic [4:0] S_DIV_WAIT  = 5'd9;
   localparam logic [4:0] S_BIN_CLAMP = 5'd10;
   localparam logic [4:0] S_MEM_RD    = 5'd11;
   localparam logic [4:0] S_MEM_CHK   = 5'd12;
   localparam logic [4:0] S_T_DIV     = 5'd13;
   localparam logic [4:0] S_T_WAIT    = 5'd14;
   localparam logic [4:0] S_SQ_INIT   = 5'd15;
   localparam logic [4:0] S_SQ        = 5'd16;
   localparam logic [4:0] S_L_MUL     = 5'd17;
   localparam logic [4:0] S_L_SUM     = 5'd18;
   localparam logic [4:0] S_C1        = 5'd19;
   localparam logic [4:0] S_C2        = 5'd20;
   localparam logic [4:0] S_V_MUL     = 5'd21;
   localparam logic [4:0] S_V_DIV     = 5'd22;
   localparam logic [4:0] S_V_WAIT    = 5'd23;
   localparam logic [4:0] S_TGT       = 5'd24;
   localparam logic [4:0] S_RESP      = 5'd25;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic [4:0] op;

   // next state and operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_RST_CLR: begin
            op = OP_CLR_STEP;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op       = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.req_code)
               REQ_START:  state_in = S_CLR;
               REQ_BOUNDS: state_in = S_BOUNDS;
               REQ_SAMPLE: state_in = S_TAKEN;
               default:    state_in = S_RESP;
            endcase
         end
         S_CLR: begin
            op = OP_CLR_STEP;
            if (stat.clr_last) state_in = S_INIT;
         end
         S_INIT: begin
            op       = OP_ROUND_INIT;
            state_in = S_RESP;
         end
         S_BOUNDS: begin
            op       = OP_BOUNDS;
            state_in = S_RESP;
         end
         S_TAKEN: begin
            op       = OP_TAKEN;
            state_in = S_DIM;
         end
         S_DIM: begin
            if (!stat.in_range) begin
               if (stat.dim_last) state_in = S_RESP;
               else op = OP_NEXT_DIM;
            end else if (stat.zero_range) begin
               op       = OP_BIN_ZERO;
               state_in = S_MEM_RD;
            end else begin
               op       = OP_BIN_MUL;
               state_in = S_BIN_DIV;
            end
         end
         S_BIN_DIV: begin
            op       = OP_BIN_DIV;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT:  if (stat.div_done) state_in = S_BIN_CLAMP;
         S_BIN_CLAMP: begin
            op       = OP_BIN_CLAMP;
            state_in = S_MEM_RD;
         end
         S_MEM_RD: begin
            op       = OP_MEM_RD;
            state_in = S_MEM_CHK;
         end
         S_MEM_CHK: begin
            if (!stat.mark_set) begin
               op       = OP_MARK;
               state_in = stat.occ_nz ? S_T_DIV : S_RESP;
            end else if (stat.dim_last) begin
               state_in = S_RESP;
            end else begin
               op       = OP_NEXT_DIM;
               state_in = S_DIM;
            end
         end
         S_T_DIV: begin
            op       = OP_T_DIV;
            state_in = S_T_WAIT;
         end
         S_T_WAIT:  if (stat.div_done) state_in = S_SQ_INIT;
         S_SQ_INIT: begin
            op       = OP_SQ_INIT;
            state_in = S_SQ;
         end
         S_SQ: begin
            op = OP_SQ_STEP;
            if (stat.sq_last) state_in = S_L_MUL;
         end
         S_L_MUL: begin
            op       = OP_L_MUL;
            state_in = S_L_SUM;
         end
         S_L_SUM: begin
            op       = OP_L_SUM;
            state_in = S_C1;
         end
         S_C1: begin
            op       = OP_C_MUL1;
            state_in = S_C2;
         end
         S_C2: begin
            op       = OP_C_MUL2;
            state_in = S_V_MUL;
         end
         S_V_MUL: begin
            op       = OP_V_MUL;
            state_in = S_V_DIV;
         end
         S_V_DIV: begin
            op       = OP_V_DIV;
            state_in = S_V_WAIT;
         end
         S_V_WAIT: if (stat.div_done) state_in = S_TGT;
         S_TGT: begin
            op       = OP_TGT_SET;
            state_in = S_RESP;
         end
         S_RESP: begin
            op       = OP_RESP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_RST_CLR;
      else       state_ff <= state_in;
   end

   assign busy   = state_ff != S_IDLE;
   assign cmd.op = op;

   // an accepted item always goes to decode
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> (state_ff == S_DECODE))
      else $error("accepted item not decoded");

   // a result is followed by idle
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> (state_ff == S_IDLE)) else $error("result not closing item");

endmodule

FILE: hdl/kld_sample_size_bound_unit.sv
// Sample size bound unit. An item is taken when start is high and busy is low; its one
// result appears on rsp_data with rsp_valid high for exactly one cycle, and the receiver
// cannot stall it. After reset, and on every start-round item, the unit sweeps its
// 1024-entry bin mark memory one entry a cycle, with busy high. A sample item tests its
// dimensions in turn: an in-range dimension gets its bin index from the shared
// one-bit-per-cycle divider (skipped when the range is empty), and when a new bin raises
// the occupied count above one the target follows: two divisions and a square root.
// depends on kld_pkg, kld_ctrl, kld_dp
module kld_sample_size_bound_unit
   import kld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  kld_req_type req_data,
   output logic        rsp_valid,
   output kld_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [8:0]   num_bins_ff;
   logic [15:0]  eps_ff;
   logic [15:0]  min_samples_ff;
   logic         csr_wr;
   kld_cmd_type  cmd;
   kld_stat_type stat;

   // configuration registers
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff    <= NUM_BINS_RST;
         eps_ff         <= EPS_RST;
         min_samples_ff <= MIN_SAMPLES_RST;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_NUM_BINS:    num_bins_ff    <= pwdata[8:0];
            REG_EPSILON:     eps_ff         <= pwdata[15:0];
            REG_MIN_SAMPLES: min_samples_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (paddr[3:2])
         REG_NUM_BINS:    prdata = {23'd0, num_bins_ff};
         REG_EPSILON:     prdata = {16'd0, eps_ff};
         REG_MIN_SAMPLES: prdata = {16'd0, min_samples_ff};
         default:         prdata = 32'd0;
      endcase
   end

   kld_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   kld_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_in      (req_data),
      .num_bins    (num_bins_ff),
      .epsilon     (eps_ff),
      .min_samples (min_samples_ff),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking testbench of the sample size bound unit, with a predictor built in
// depends on kld_pkg and kld_sample_size_bound_unit
`timescale 1ns / 1ps

module tb;
   import kld_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 600;
   // request code with no defined meaning
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   kld_req_type req_data;
   logic        rsp_valid;
   kld_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   kld_sample_size_bound_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predicted unit state and registers
   logic        bin_seen [MARK_DEPTH];
   longint      lo_bound [DIMS];
   longint      hi_bound [DIMS];
   int unsigned occ_cnt;
   int unsigned taken_cnt;
   logic [63:0] target_q16;
   logic [8:0]  cfg_bins;
   logic [15:0] cfg_eps;
   logic [15:0] cfg_min;

   // bounds last queued per dimension, used to aim the samples
   longint      lo_gen [DIMS];
   longint      hi_gen [DIMS];

   kld_req_type pending_items [$];
   kld_rsp_type expected_counts [$];
   int          errors;
   int          n_items;
   int          n_new_bins;
   int          n_done;
   int          n_writes;
   int          idle_pct;
   bit          drain_each;
   bit          took;
   int          quiet_cycles;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want, n_items);
      errors++;
   endtask

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // wilson-hilferty target in q24.16 for n degrees of freedom
   function automatic logic [63:0] kld_target(input logic [63:0] n, input logic [15:0] eps);
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] l;
      logic [63:0] l24;
      logic [63:0] c;
      logic [63:0] e;
      logic [63:0] v;
      t   = (64'd1 << 33) / (64'd9 * n);
      s   = int_sqrt(t << 32);
      l   = (64'd1 << 32) - t + ((s * 64'(Z_Q16)) >> 16);
      l24 = l >> 8;
      c   = (((l24 * l24) >> 24) * l24) >> 24;
      e   = (eps == 0) ? 64'd1 : 64'(eps);
      v   = (n * 64'd32768 * c) / (e * 64'd256);
      return (v > 64'(TARGET_MAX)) ? 64'(TARGET_MAX) : v;
   endfunction

   function automatic void clear_round();
      foreach (bin_seen[i]) bin_seen[i] = 1'b0;
      occ_cnt    = 0;
      taken_cnt  = 0;
      target_q16 = 64'(cfg_min) << 16;
   endfunction

   function automatic kld_rsp_type predict_counts(input kld_req_type r);
      kld_rsp_type o;
      longint      comp [DIMS];
      longint      nb;
      longint      s;
      longint      span;
      longint      bin;
      int          idx;
      bit          newb;
      newb = 0;
      comp[0] = longint'(r.sample_0);
      comp[1] = longint'(r.sample_1);
      comp[2] = longint'(r.sample_2);
      comp[3] = longint'(r.sample_3);
      if (r.req_type == REQ_START) begin
         clear_round();
      end else if (r.req_type == REQ_BOUNDS) begin
         lo_bound[r.dim_index] = longint'(r.bound_low);
         hi_bound[r.dim_index] = longint'(r.bound_high);
      end else if (r.req_type == REQ_SAMPLE) begin
         nb = (cfg_bins == 0) ? 1 : (cfg_bins > MAX_BINS) ? MAX_BINS : cfg_bins;
         if (taken_cnt < TAKEN_MAX) taken_cnt++;
         // first in-range component landing in an empty bin wins
         for (int d = 0; d < DIMS; d++) begin
            s = comp[d];
            if (!newb && s >= lo_bound[d] && s <= hi_bound[d]) begin
               span = hi_bound[d] - lo_bound[d];
               bin  = (span == 0) ? 0 : ((s - lo_bound[d]) * nb) / span;
               if (bin >= nb) bin = nb - 1;
               idx = d * MAX_BINS + int'(bin);
               if (!bin_seen[idx]) begin
                  bin_seen[idx] = 1'b1;
                  newb = 1;
                  if (occ_cnt < OCC_MAX) occ_cnt++;
                  if (occ_cnt > 1) target_q16 = kld_target(64'(occ_cnt - 1), cfg_eps);
               end
            end
         end
      end
      o.new_bin       = newb;
      o.bins_occupied = occ_cnt[10:0];
      o.samples_taken = taken_cnt[23:0];
      o.sample_target = ((target_q16 >> 16) > 64'(TAKEN_MAX)) ? TAKEN_MAX
                                                              : target_q16[39:16];
      o.done_res      = ((64'(taken_cnt) << 16) >= target_q16) && (taken_cnt >= cfg_min);
      return o;
   endfunction

   // driver: next item goes out at a falling edge once the previous was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (pending_items.size() > 0 && !(drain_each && expected_counts.size() > 0)
             && !(start && drain_each) && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_items.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results, item acceptance and register writes at the rising edge
   always @(posedge clock) begin
      kld_rsp_type want;
      took = 1'b0;
      if (reset) begin
         cfg_bins = NUM_BINS_RST;
         cfg_eps  = EPS_RST;
         cfg_min  = MIN_SAMPLES_RST;
         for (int d = 0; d < DIMS; d++) begin
            lo_bound[d] = 0;
            hi_bound[d] = 0;
         end
         clear_round();
         expected_counts.delete();
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (expected_counts.size() == 0) begin
               $display("result with no item waiting");
               errors++;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_data.new_bin !== want.new_bin)
                  report_mismatch("new_bin", rsp_data.new_bin, want.new_bin);
               if (rsp_data.bins_occupied !== want.bins_occupied)
                  report_mismatch("bins_occupied", rsp_data.bins_occupied, want.bins_occupied);
               if (rsp_data.samples_taken !== want.samples_taken)
                  report_mismatch("samples_taken", rsp_data.samples_taken, want.samples_taken);
               if (rsp_data.sample_target !== want.sample_target)
                  report_mismatch("sample_target", rsp_data.sample_target, want.sample_target);
               if (rsp_data.done_res !== want.done_res)
                  report_mismatch("done_res", rsp_data.done_res, want.done_res);
               if (want.new_bin) n_new_bins++;
               if (want.done_res) n_done++;
            end
         end
         if (start && !busy) begin
            took = 1'b1;
            quiet_cycles = 0;
            expected_counts.push_back(predict_counts(req_data));
            n_items++;
         end
         if (psel && penable && pwrite && pready) begin
            quiet_cycles = 0;
            n_writes++;
            case (paddr[3:2])
               REG_NUM_BINS:    cfg_bins = pwdata[8:0];
               REG_EPSILON:     cfg_eps  = pwdata[15:0];
               REG_MIN_SAMPLES: cfg_min  = pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (!reset && quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("[kld_sample_size_bound_unit] ERROR");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom_range(65535)), value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() > 0 || start || expected_counts.size() > 0 || busy)
         @(negedge clock);
   endtask

   function automatic kld_req_type noise_item(input logic [1:0] kind);
      kld_req_type  r;
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r   = raw[$bits(kld_req_type)-1:0];
      r.req_type = kind;
      return r;
   endfunction

   function automatic longint pick_between(input longint lo, input longint hi);
      longint span;
      span = hi - lo;
      if (span <= 0) return lo;
      return lo + longint'({$urandom, $urandom} % (span + 1));
   endfunction

   function automatic kld_req_type bounds_item(input logic [1:0] dim);
      kld_req_type r;
      longint      lo;
      longint      hi;
      int          sel;
      r   = noise_item(REQ_BOUNDS);
      sel = $urandom_range(99);
      lo  = longint'($signed($urandom)) >>> $urandom_range(16);
      if (sel < 80) hi = lo + (longint'($urandom) >> $urandom_range(31));
      else if (sel < 90) hi = lo;
      else hi = lo - 1 - $urandom_range(100000);
      if (hi > 2147483647) hi = 2147483647;
      if (hi < -2147483648) hi = -2147483648;
      r.dim_index  = dim;
      r.bound_low  = lo[31:0];
      r.bound_high = hi[31:0];
      return r;
   endfunction

   // mostly in-range components, with some at the bounds and some anywhere
   function automatic kld_req_type sample_item();
      kld_req_type r;
      logic [31:0] v [DIMS];
      int          sel;
      r = noise_item(REQ_SAMPLE);
      for (int d = 0; d < DIMS; d++) begin
         sel = $urandom_range(99);
         if (sel < 75) v[d] = 32'(pick_between(lo_gen[d], hi_gen[d]));
         else if (sel < 80) v[d] = lo_gen[d][31:0];
         else if (sel < 85) v[d] = hi_gen[d][31:0];
         else v[d] = $urandom;
      end
      r.sample_0 = v[0];
      r.sample_1 = v[1];
      r.sample_2 = v[2];
      r.sample_3 = v[3];
      return r;
   endfunction

   task automatic queue_bounds(input logic [1:0] dim);
      kld_req_type r;
      r = bounds_item(dim);
      lo_gen[dim] = longint'(r.bound_low);
      hi_gen[dim] = longint'(r.bound_high);
      pending_items.push_back(r);
   endtask

   function automatic kld_req_type make_bounds(input logic [1:0] dim, input longint lo,
                                               input longint hi);
      kld_req_type r;
      r = noise_item(REQ_BOUNDS);
      r.dim_index  = dim;
      r.bound_low  = lo[31:0];
      r.bound_high = hi[31:0];
      return r;
   endfunction

   function automatic kld_req_type make_sample(input longint a, input longint b,
                                               input longint c, input longint d);
      kld_req_type r;
      r = noise_item(REQ_SAMPLE);
      r.sample_0 = a[31:0];
      r.sample_1 = b[31:0];
      r.sample_2 = c[31:0];
      r.sample_3 = d[31:0];
      return r;
   endfunction

   initial begin
      logic [15:0] phase_cfg [9][3];
      int          sel;
      phase_cfg = '{'{0, 0, 0}, '{1, 1, 1}, '{256, 65535, 65535}, '{511, 6554, 1800},
                    '{2, 300, 200}, '{16, 6554, 50}, '{150, 1000, 500},
                    '{64, 20000, 1000}, '{8, 65535, 10}};
      errors = 0; n_items = 0; n_new_bins = 0; n_done = 0; n_writes = 0;
      idle_pct = 27; drain_each = 1; took = 0; quiet_cycles = 0;
      start = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      wait_idle();

      // directed part under reset settings, one item at a time
      pending_items.push_back(noise_item(REQ_START));
      pending_items.push_back(noise_item(REQ_UNUSED));
      pending_items.push_back(make_bounds(2'd0, -2147483648, 2147483647));
      pending_items.push_back(make_bounds(2'd1, 100, 100));
      pending_items.push_back(make_bounds(2'd2, 10, -10));
      pending_items.push_back(make_bounds(2'd3, 0, 65536));
      pending_items.push_back(make_sample(-2147483648, 100, 0, 65536));
      pending_items.push_back(make_sample(2147483647, 100, 0, 65536));
      pending_items.push_back(make_sample(-2147483648, 100, 0, 65536));
      pending_items.push_back(make_sample(-2147483648, 100, 0, 65536));
      pending_items.push_back(make_sample(-2147483648, 99, 5, 0));
      pending_items.push_back(make_sample(0, 101, 0, 70000));
      pending_items.push_back(make_sample(1000, 0, 0, 32768));
      pending_items.push_back(make_bounds(2'd3, 65536, 0));
      pending_items.push_back(make_sample(-2147483648, 99, 5, 100));
      pending_items.push_back(noise_item(REQ_UNUSED));
      pending_items.push_back(noise_item(REQ_START));
      pending_items.push_back(make_sample(0, 100, 0, 0));
      wait_idle();
      drain_each = 0;

      // random phases, one register setting each
      for (int p = 0; p < 9; p++) begin
         idle_pct = (p < 3) ? 27 : (p < 6) ? 59 : 0;
         if (p == 4) drain_each = 1;
         csr_write(REG_NUM_BINS, phase_cfg[p][0]);
         csr_write(REG_EPSILON, phase_cfg[p][1]);
         csr_write(REG_MIN_SAMPLES, phase_cfg[p][2]);
         pending_items.push_back(noise_item(REQ_START));
         for (int d = 0; d < DIMS; d++) queue_bounds(d[1:0]);
         for (int k = 0; k < 165; k++) begin
            if (p == 4 && k == 20) drain_each = 0;
            sel = $urandom_range(99);
            if (sel < 85) pending_items.push_back(sample_item());
            else if (sel < 92) queue_bounds(2'($urandom_range(3)));
            else if (sel < 95) pending_items.push_back(noise_item(REQ_SAMPLE));
            else if (sel < 97) pending_items.push_back(noise_item(REQ_UNUSED));
            else if (sel < 99) pending_items.push_back(noise_item(REQ_BOUNDS));
            else pending_items.push_back(noise_item(REQ_START));
         end
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d items over 9 register settings, %0d register writes", n_items,
               n_writes);
      $display("%0d items opened a new bin, %0d reported the round done", n_new_bins, n_done);
      if (errors == 0 && expected_counts.size() == 0) begin
         $display("[kld_sample_size_bound_unit] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_counts.size());
         $display("[kld_sample_size_bound_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/kld_pkg.sv
hdl/kld_div.sv
hdl/kld_dp.sv
hdl/kld_ctrl.sv
hdl/kld_sample_size_bound_unit.sv
tb/sv/tb.sv
